@@ sv/mcwp_pkg.sv @@
// ----------------------------------------------------------------------------
// mcwp_pkg
// Shared types and constants for the motion command word parser: character
// codes, field selects, status and axis codes, and register indexes.
// ----------------------------------------------------------------------------
package mcwp_pkg;

    localparam int FIELD_LEN = 6;
    localparam int NUM_AXES  = 3;
    localparam int VAL_W     = 17;

    typedef logic [3:0]       code_t;
    typedef logic [VAL_W-1:0] val_t;
    typedef logic [FIELD_LEN-1:0][3:0] axis_codes_t;

    // Stored character codes.
    localparam code_t CODE_DOT   = 4'd10;
    localparam code_t CODE_EMPTY = 4'd15;

    // Field select codes.
    localparam logic [2:0] FIELD_NONE = 3'd0;
    localparam logic [2:0] FIELD_X    = 3'd1;
    localparam logic [2:0] FIELD_Y    = 3'd2;
    localparam logic [2:0] FIELD_Z    = 3'd3;
    localparam logic [2:0] FIELD_F    = 3'd4;

    // Result status codes.
    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_CANCEL   = 3'd1;
    localparam logic [2:0] STATUS_BAD_CHAR = 3'd2;
    localparam logic [2:0] STATUS_BAD_NUM  = 3'd3;
    localparam logic [2:0] STATUS_LIMIT    = 3'd4;

    // Error axis codes.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;
    localparam logic [1:0] AXIS_F = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_X_LIMIT = 3'd0;
    localparam logic [2:0] REG_Y_LIMIT = 3'd1;
    localparam logic [2:0] REG_Z_LIMIT = 3'd2;
    localparam logic [2:0] REG_X_HOLD  = 3'd3;
    localparam logic [2:0] REG_Y_HOLD  = 3'd4;
    localparam logic [2:0] REG_Z_HOLD  = 3'd5;

    localparam val_t LIMIT_RESET = 17'd99999;

    // ASCII bytes of interest.
    localparam logic [7:0] ASCII_CR    = 8'h0D;
    localparam logic [7:0] ASCII_ETX   = 8'h03;
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_DOT   = 8'h2E;
    localparam logic [7:0] ASCII_0     = 8'h30;
    localparam logic [7:0] ASCII_9     = 8'h39;
    localparam logic [7:0] ASCII_X_UP  = 8'h58;
    localparam logic [7:0] ASCII_X_LO  = 8'h78;
    localparam logic [7:0] ASCII_Y_UP  = 8'h59;
    localparam logic [7:0] ASCII_Y_LO  = 8'h79;
    localparam logic [7:0] ASCII_Z_UP  = 8'h5A;
    localparam logic [7:0] ASCII_Z_LO  = 8'h7A;
    localparam logic [7:0] ASCII_F_UP  = 8'h46;
    localparam logic [7:0] ASCII_F_LO  = 8'h66;

    // Event raised by the byte handler for the result stage.
    typedef struct packed {
        logic       finish;
        logic       error;
        logic [2:0] status;
        logic [1:0] axis;
    } byte_evt_t;

    // Outcome of one axis at end of command.
    typedef struct packed {
        logic bad;
        logic over;
        val_t val;
    } axis_res_t;

endpackage

@@ sv/mcwp_axis_eval.sv @@
// ----------------------------------------------------------------------------
// mcwp_axis_eval
// Checks the six stored characters of one axis against the accepted number
// shapes, converts the value to mils and compares it with the axis limit.
// ----------------------------------------------------------------------------
module mcwp_axis_eval (
    input  mcwp_pkg::axis_codes_t codes,
    input  mcwp_pkg::val_t        limit,
    input  mcwp_pkg::val_t        hold,
    output mcwp_pkg::axis_res_t   res
);

    function automatic logic is_dig(input mcwp_pkg::code_t c);
        return c <= 4'd9;
    endfunction

    function automatic logic dig_or_empty(input mcwp_pkg::code_t c);
        return (c <= 4'd9) || (c == mcwp_pkg::CODE_EMPTY);
    endfunction

    function automatic mcwp_pkg::val_t dval(input mcwp_pkg::code_t c);
        return (c <= 4'd9) ? mcwp_pkg::val_t'(c) : '0;
    endfunction

    logic           tail3;
    logic           rest_empty;
    logic           empty_axis;
    logic           shape_ok;
    mcwp_pkg::val_t mils;

    always_comb begin
        tail3 = dig_or_empty(codes[3]) && dig_or_empty(codes[4]) && dig_or_empty(codes[5]);
        rest_empty = (codes[2] == mcwp_pkg::CODE_EMPTY) && (codes[3] == mcwp_pkg::CODE_EMPTY)
                  && (codes[4] == mcwp_pkg::CODE_EMPTY) && (codes[5] == mcwp_pkg::CODE_EMPTY);
        empty_axis = 1'b0;
        shape_ok   = 1'b1;
        mils       = '0;
        if (codes[0] == mcwp_pkg::CODE_DOT && is_dig(codes[1]) && dig_or_empty(codes[2])
                && tail3) begin
            mils = dval(codes[1]) * 17'd100 + dval(codes[2]) * 17'd10 + dval(codes[3]);
        end else if (is_dig(codes[0]) && codes[1] == mcwp_pkg::CODE_DOT && is_dig(codes[2])
                && tail3) begin
            mils = dval(codes[0]) * 17'd1000 + dval(codes[2]) * 17'd100
                 + dval(codes[3]) * 17'd10 + dval(codes[4]);
        end else if (is_dig(codes[0]) && is_dig(codes[1]) && codes[2] == mcwp_pkg::CODE_DOT
                && tail3) begin
            mils = dval(codes[0]) * 17'd10000 + dval(codes[1]) * 17'd1000
                 + dval(codes[3]) * 17'd100 + dval(codes[4]) * 17'd10 + dval(codes[5]);
        end else if (is_dig(codes[0]) && dig_or_empty(codes[1]) && rest_empty) begin
            // One or two whole digits with no dot.
            mils = dval(codes[0]) * 17'd10000 + dval(codes[1]) * 17'd1000;
            if (codes[1] == mcwp_pkg::CODE_EMPTY) begin
                mils = dval(codes[0]) * 17'd1000;
            end
        end else if (codes[0] == mcwp_pkg::CODE_EMPTY && codes[1] == mcwp_pkg::CODE_EMPTY
                && rest_empty) begin
            empty_axis = 1'b1;
        end else begin
            shape_ok = 1'b0;
        end

        res.bad  = !shape_ok;
        // An axis that was not given takes its hold value and skips the limit check.
        res.over = shape_ok && !empty_axis && (mils > limit);
        if (!shape_ok) begin
            res.val = '0;
        end else if (empty_axis) begin
            res.val = hold;
        end else begin
            res.val = mils;
        end
    end

endmodule

@@ sv/mcwp_cmd_store.sv @@
// ----------------------------------------------------------------------------
// mcwp_cmd_store
// Per-byte command state: the character store, the selected field, the write
// position and the discard flag. Raises finish and error events.
// ----------------------------------------------------------------------------
module mcwp_cmd_store (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             byte_accept,
    input  logic [7:0]                       rx_byte,
    output mcwp_pkg::axis_codes_t [2:0]      store,
    output mcwp_pkg::byte_evt_t              evt
);

    mcwp_pkg::axis_codes_t [2:0] store_reg, store_next;
    logic [2:0]                  sel_reg, sel_next;
    logic [2:0]                  idx_reg, idx_next;
    logic                        discard_reg, discard_next;

    logic            is_char;
    mcwp_pkg::code_t code;

    always_comb begin
        is_char = 1'b0;
        code    = mcwp_pkg::CODE_EMPTY;
        if (rx_byte >= mcwp_pkg::ASCII_0 && rx_byte <= mcwp_pkg::ASCII_9) begin
            is_char = 1'b1;
            code    = 4'(rx_byte - mcwp_pkg::ASCII_0);
        end else if (rx_byte == mcwp_pkg::ASCII_DOT) begin
            is_char = 1'b1;
            code    = mcwp_pkg::CODE_DOT;
        end
    end

    always_comb begin
        store_next   = store_reg;
        sel_next     = sel_reg;
        idx_next     = idx_reg;
        discard_next = discard_reg;
        evt          = '0;
        if (byte_accept) begin
            if (discard_reg) begin
                if (rx_byte == mcwp_pkg::ASCII_CR) begin
                    store_next   = {(mcwp_pkg::NUM_AXES*mcwp_pkg::FIELD_LEN){mcwp_pkg::CODE_EMPTY}};
                    sel_next     = mcwp_pkg::FIELD_NONE;
                    idx_next     = '0;
                    discard_next = 1'b0;
                end
            end else if (rx_byte == mcwp_pkg::ASCII_CR) begin
                evt.finish   = 1'b1;
                store_next   = {(mcwp_pkg::NUM_AXES*mcwp_pkg::FIELD_LEN){mcwp_pkg::CODE_EMPTY}};
                sel_next     = mcwp_pkg::FIELD_NONE;
                idx_next     = '0;
            end else if (rx_byte == mcwp_pkg::ASCII_ETX) begin
                evt.error    = 1'b1;
                evt.status   = mcwp_pkg::STATUS_CANCEL;
                evt.axis     = mcwp_pkg::AXIS_X;
                discard_next = 1'b1;
            end else if (rx_byte == mcwp_pkg::ASCII_SPACE) begin
                // Spaces are skipped.
            end else if (rx_byte == mcwp_pkg::ASCII_X_UP || rx_byte == mcwp_pkg::ASCII_X_LO) begin
                sel_next = mcwp_pkg::FIELD_X;
                idx_next = '0;
            end else if (rx_byte == mcwp_pkg::ASCII_Y_UP || rx_byte == mcwp_pkg::ASCII_Y_LO) begin
                sel_next = mcwp_pkg::FIELD_Y;
                idx_next = '0;
            end else if (rx_byte == mcwp_pkg::ASCII_Z_UP || rx_byte == mcwp_pkg::ASCII_Z_LO) begin
                sel_next = mcwp_pkg::FIELD_Z;
                idx_next = '0;
            end else if (rx_byte == mcwp_pkg::ASCII_F_UP || rx_byte == mcwp_pkg::ASCII_F_LO) begin
                sel_next = mcwp_pkg::FIELD_F;
                idx_next = '0;
            end else if (sel_reg != mcwp_pkg::FIELD_NONE) begin
                if (!is_char) begin
                    evt.error    = 1'b1;
                    evt.status   = mcwp_pkg::STATUS_BAD_CHAR;
                    evt.axis     = 2'(sel_reg - 3'd1);
                    discard_next = 1'b1;
                end else if (idx_reg >= 3'(mcwp_pkg::FIELD_LEN)) begin
                    // A seventh character deselects the field.
                    sel_next = mcwp_pkg::FIELD_NONE;
                end else begin
                    for (int f = 0; f < mcwp_pkg::NUM_AXES; f++) begin
                        for (int i = 0; i < mcwp_pkg::FIELD_LEN; i++) begin
                            if (sel_reg == 3'(f + 1) && idx_reg == 3'(i)) begin
                                store_next[f][i] = code;
                            end
                        end
                    end
                    idx_next = 3'(idx_reg + 3'd1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            store_reg   <= {(mcwp_pkg::NUM_AXES*mcwp_pkg::FIELD_LEN){mcwp_pkg::CODE_EMPTY}};
            sel_reg     <= mcwp_pkg::FIELD_NONE;
            idx_reg     <= '0;
            discard_reg <= 1'b0;
        end else begin
            store_reg   <= store_next;
            sel_reg     <= sel_next;
            idx_reg     <= idx_next;
            discard_reg <= discard_next;
        end
    end

    assign store = store_reg;

endmodule

@@ sv/motion_command_word_parser_core.sv @@
// ----------------------------------------------------------------------------
// motion_command_word_parser_core
// Parses the coordinate words of a motion command one ASCII byte at a time
// and gives one result per command with positions in mils or an error code.
// ----------------------------------------------------------------------------
// Throughput: one byte accepted per cycle; s_ready drops only while a result
// sits in the output register and m_ready is low.
// A result is registered and valid in the cycle after the byte that caused it
// (carriage return, cancel or bad character); it is held in the output register.
// Reset clears the command state and the output valid, and loads the limits
// with 99999 and the hold positions with 0.
module motion_command_word_parser_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [1:0]  m_error_axis,
    output logic [16:0] m_x_mils,
    output logic [16:0] m_y_mils,
    output logic [16:0] m_z_mils,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    mcwp_pkg::val_t [2:0] limit_reg;
    mcwp_pkg::val_t [2:0] hold_reg;

    logic                        byte_accept;
    mcwp_pkg::axis_codes_t [2:0] store;
    mcwp_pkg::byte_evt_t         evt;
    mcwp_pkg::axis_res_t [2:0]   res;

    logic       m_valid_reg, m_valid_next;
    logic [2:0] status_reg, status_next;
    logic [1:0] axis_reg, axis_next;
    mcwp_pkg::val_t [2:0] mils_reg, mils_next;

    assign cfg_ready   = 1'b1;
    assign s_ready     = !m_valid_reg || m_ready;
    assign byte_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= {3{mcwp_pkg::LIMIT_RESET}};
            hold_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                mcwp_pkg::REG_X_LIMIT: limit_reg[0] <= cfg_data;
                mcwp_pkg::REG_Y_LIMIT: limit_reg[1] <= cfg_data;
                mcwp_pkg::REG_Z_LIMIT: limit_reg[2] <= cfg_data;
                mcwp_pkg::REG_X_HOLD:  hold_reg[0]  <= cfg_data;
                mcwp_pkg::REG_Y_HOLD:  hold_reg[1]  <= cfg_data;
                mcwp_pkg::REG_Z_HOLD:  hold_reg[2]  <= cfg_data;
                default: ;
            endcase
        end
    end

    mcwp_cmd_store u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .rx_byte     (s_rx_byte),
        .store       (store),
        .evt         (evt)
    );

    for (genvar a = 0; a < mcwp_pkg::NUM_AXES; a++) begin : g_axis
        mcwp_axis_eval u_eval (
            .codes (store[a]),
            .limit (limit_reg[a]),
            .hold  (hold_reg[a]),
            .res   (res[a])
        );
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        status_next  = status_reg;
        axis_next    = axis_reg;
        mils_next    = mils_reg;
        if (evt.error) begin
            m_valid_next = 1'b1;
            status_next  = evt.status;
            axis_next    = evt.axis;
            mils_next    = '0;
        end else if (evt.finish) begin
            m_valid_next = 1'b1;
            status_next  = mcwp_pkg::STATUS_OK;
            axis_next    = mcwp_pkg::AXIS_X;
            mils_next    = {res[2].val, res[1].val, res[0].val};
            // Shape errors win over limit errors; the last failing axis is named.
            if (res[0].bad || res[1].bad || res[2].bad) begin
                status_next = mcwp_pkg::STATUS_BAD_NUM;
                if (res[2].bad) begin
                    axis_next = mcwp_pkg::AXIS_Z;
                end else if (res[1].bad) begin
                    axis_next = mcwp_pkg::AXIS_Y;
                end
            end else if (res[0].over || res[1].over || res[2].over) begin
                status_next = mcwp_pkg::STATUS_LIMIT;
                if (res[2].over) begin
                    axis_next = mcwp_pkg::AXIS_Z;
                end else if (res[1].over) begin
                    axis_next = mcwp_pkg::AXIS_Y;
                end
            end
            if (status_next != mcwp_pkg::STATUS_OK) begin
                mils_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        axis_reg   <= axis_next;
        mils_reg   <= mils_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_error_axis = axis_reg;
    assign m_x_mils     = mils_reg[0];
    assign m_y_mils     = mils_reg[1];
    assign m_z_mils     = mils_reg[2];

    // A carriage return or an error always presents a result in the next cycle.
    a_event_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (evt.finish || evt.error) |=> m_valid_reg)
        else $error("command event did not produce a result");

    // Only one event can come from one byte.
    a_single_event: assert property (@(posedge aclk) disable iff (!aresetn)
        !(evt.finish && evt.error))
        else $error("finish and error raised together");

    // Failed commands carry no positions.
    a_error_zero_mils: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_reg != mcwp_pkg::STATUS_OK) |->
            (mils_reg[0] == '0 && mils_reg[1] == '0 && mils_reg[2] == '0))
        else $error("positions not cleared on a failed command");

    // Success and cancel name no failing axis.
    a_axis_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (status_reg == mcwp_pkg::STATUS_OK ||
                         status_reg == mcwp_pkg::STATUS_CANCEL)) |->
            (axis_reg == mcwp_pkg::AXIS_X))
        else $error("error axis set on a result without an axis failure");

    // A status code beyond the defined set is never produced.
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (status_reg <= mcwp_pkg::STATUS_LIMIT))
        else $error("undefined status code");

endmodule

@@ tb/sv/motion_command_word_parser_core_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_command_word_parser_core_chk
// Watches the byte, result and register channels of the parser. It keeps its
// own copy of the command state and registers, predicts the result of every
// accepted byte, and compares each result item field by field.
// ----------------------------------------------------------------------------
module motion_command_word_parser_core_chk (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_status,
    input  logic [1:0]  m_error_axis,
    input  logic [16:0] m_x_mils,
    input  logic [16:0] m_y_mils,
    input  logic [16:0] m_z_mils,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data,
    output int          error_count,
    output int          pending
);

    localparam logic [1:0] SHAPE_OK    = 2'd0;
    localparam logic [1:0] SHAPE_EMPTY = 2'd1;
    localparam logic [1:0] SHAPE_BAD   = 2'd2;

    typedef struct packed {
        logic [2:0]     status;
        logic [1:0]     axis;
        mcwp_pkg::val_t x;
        mcwp_pkg::val_t y;
        mcwp_pkg::val_t z;
    } cmd_result_t;

    cmd_result_t           results_due [$];
    mcwp_pkg::axis_codes_t char_store [mcwp_pkg::NUM_AXES];
    logic [2:0]            field_sel;
    logic [2:0]            char_pos;
    logic                  dropping;
    mcwp_pkg::val_t        axis_limit [mcwp_pkg::NUM_AXES];
    mcwp_pkg::val_t        axis_hold  [mcwp_pkg::NUM_AXES];

    function automatic logic is_digit(input mcwp_pkg::code_t c);
        return c <= 4'd9;
    endfunction

    function automatic logic digit_or_empty(input mcwp_pkg::code_t c);
        return c <= 4'd9 || c == mcwp_pkg::CODE_EMPTY;
    endfunction

    function automatic logic [2:0] letter_field(input logic [7:0] b);
        if (b == mcwp_pkg::ASCII_X_UP || b == mcwp_pkg::ASCII_X_LO) return mcwp_pkg::FIELD_X;
        if (b == mcwp_pkg::ASCII_Y_UP || b == mcwp_pkg::ASCII_Y_LO) return mcwp_pkg::FIELD_Y;
        if (b == mcwp_pkg::ASCII_Z_UP || b == mcwp_pkg::ASCII_Z_LO) return mcwp_pkg::FIELD_Z;
        if (b == mcwp_pkg::ASCII_F_UP || b == mcwp_pkg::ASCII_F_LO) return mcwp_pkg::FIELD_F;
        return mcwp_pkg::FIELD_NONE;
    endfunction

    // Matches the stored characters of one axis against the accepted number
    // shapes and gives the value in mils. Digits past the third decimal fall off.
    function automatic logic [1:0] decode_axis(input mcwp_pkg::axis_codes_t c,
                                               output mcwp_pkg::val_t mils);
        int   dv [mcwp_pkg::FIELD_LEN];
        logic tail3;
        logic rest_empty;
        for (int i = 0; i < mcwp_pkg::FIELD_LEN; i++)
            dv[i] = is_digit(c[i]) ? int'(c[i]) : 0;
        tail3 = digit_or_empty(c[3]) && digit_or_empty(c[4]) && digit_or_empty(c[5]);
        rest_empty = c[2] == mcwp_pkg::CODE_EMPTY && c[3] == mcwp_pkg::CODE_EMPTY &&
                     c[4] == mcwp_pkg::CODE_EMPTY && c[5] == mcwp_pkg::CODE_EMPTY;
        mils = '0;
        if (c[0] == mcwp_pkg::CODE_DOT && is_digit(c[1]) && digit_or_empty(c[2])
                && tail3) begin
            mils = mcwp_pkg::val_t'(dv[1] * 100 + dv[2] * 10 + dv[3]);
            return SHAPE_OK;
        end
        if (is_digit(c[0]) && c[1] == mcwp_pkg::CODE_DOT && is_digit(c[2]) && tail3) begin
            mils = mcwp_pkg::val_t'(dv[0] * 1000 + dv[2] * 100 + dv[3] * 10 + dv[4]);
            return SHAPE_OK;
        end
        if (is_digit(c[0]) && is_digit(c[1]) && c[2] == mcwp_pkg::CODE_DOT && tail3) begin
            mils = mcwp_pkg::val_t'(dv[0] * 10000 + dv[1] * 1000 + dv[3] * 100
                                    + dv[4] * 10 + dv[5]);
            return SHAPE_OK;
        end
        if (is_digit(c[0]) && digit_or_empty(c[1]) && rest_empty) begin
            mils = mcwp_pkg::val_t'(dv[0] * 1000
                                    + (is_digit(c[1]) ? dv[0] * 9000 + dv[1] * 1000 : 0));
            return SHAPE_OK;
        end
        if (c[0] == mcwp_pkg::CODE_EMPTY && c[1] == mcwp_pkg::CODE_EMPTY && rest_empty)
            return SHAPE_EMPTY;
        return SHAPE_BAD;
    endfunction

    function automatic void clear_command();
        for (int a = 0; a < mcwp_pkg::NUM_AXES; a++)
            char_store[a] = {mcwp_pkg::FIELD_LEN{mcwp_pkg::CODE_EMPTY}};
        field_sel = mcwp_pkg::FIELD_NONE;
        char_pos  = 3'd0;
        dropping  = 1'b0;
    endfunction

    function automatic void flag_error(input logic [2:0] status, input logic [1:0] axis);
        cmd_result_t r;
        r = '0;
        r.status = status;
        r.axis   = axis;
        results_due.push_back(r);
        dropping = 1'b1;
    endfunction

    // A shape error on any axis wins over a limit error; in each case the last
    // failing axis in X, Y, Z order is reported.
    function automatic void close_command();
        cmd_result_t    r;
        mcwp_pkg::val_t v [mcwp_pkg::NUM_AXES];
        mcwp_pkg::val_t m;
        logic [1:0]     shape;
        logic           bad;
        logic           over;
        logic [1:0]     bad_ax;
        logic [1:0]     over_ax;
        bad = 1'b0;
        over = 1'b0;
        bad_ax = mcwp_pkg::AXIS_X;
        over_ax = mcwp_pkg::AXIS_X;
        for (int a = 0; a < mcwp_pkg::NUM_AXES; a++) begin
            shape = decode_axis(char_store[a], m);
            if (shape == SHAPE_BAD) begin
                bad = 1'b1;
                bad_ax = 2'(a);
                v[a] = '0;
            end else if (shape == SHAPE_EMPTY) begin
                v[a] = axis_hold[a];
            end else begin
                v[a] = m;
                if (m > axis_limit[a]) begin
                    over = 1'b1;
                    over_ax = 2'(a);
                end
            end
        end
        r.status = bad ? mcwp_pkg::STATUS_BAD_NUM
                       : (over ? mcwp_pkg::STATUS_LIMIT : mcwp_pkg::STATUS_OK);
        r.axis   = bad ? bad_ax : (over ? over_ax : mcwp_pkg::AXIS_X);
        r.x = (r.status == mcwp_pkg::STATUS_OK) ? v[0] : '0;
        r.y = (r.status == mcwp_pkg::STATUS_OK) ? v[1] : '0;
        r.z = (r.status == mcwp_pkg::STATUS_OK) ? v[2] : '0;
        results_due.push_back(r);
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        mcwp_pkg::code_t code;
        logic            is_code;
        if (dropping) begin
            if (b == mcwp_pkg::ASCII_CR)
                clear_command();
        end else if (b == mcwp_pkg::ASCII_CR) begin
            close_command();
            clear_command();
        end else if (b == mcwp_pkg::ASCII_ETX) begin
            flag_error(mcwp_pkg::STATUS_CANCEL, mcwp_pkg::AXIS_X);
        end else if (letter_field(b) != mcwp_pkg::FIELD_NONE) begin
            field_sel = letter_field(b);
            char_pos  = 3'd0;
        end else if (b != mcwp_pkg::ASCII_SPACE && field_sel != mcwp_pkg::FIELD_NONE) begin
            is_code = 1'b1;
            if (b >= mcwp_pkg::ASCII_0 && b <= mcwp_pkg::ASCII_9)
                code = mcwp_pkg::code_t'(b - mcwp_pkg::ASCII_0);
            else if (b == mcwp_pkg::ASCII_DOT)
                code = mcwp_pkg::CODE_DOT;
            else begin
                code = mcwp_pkg::CODE_EMPTY;
                is_code = 1'b0;
            end
            if (!is_code) begin
                flag_error(mcwp_pkg::STATUS_BAD_CHAR, 2'(field_sel - mcwp_pkg::FIELD_X));
            end else if (char_pos >= mcwp_pkg::FIELD_LEN) begin
                // The seventh character of a field is dropped and ends the field.
                field_sel = mcwp_pkg::FIELD_NONE;
            end else begin
                // Feedrate characters are counted but never stored.
                if (field_sel != mcwp_pkg::FIELD_F)
                    char_store[field_sel - mcwp_pkg::FIELD_X][char_pos] = code;
                char_pos = char_pos + 3'd1;
            end
        end
    endfunction

    function automatic void check_field(input string name, input int wanted, input int got);
        if (wanted != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, wanted, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        cmd_result_t want;
        if (!aresetn) begin
            clear_command();
            for (int a = 0; a < mcwp_pkg::NUM_AXES; a++) begin
                axis_limit[a] = mcwp_pkg::LIMIT_RESET;
                axis_hold[a]  = '0;
            end
            results_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    mcwp_pkg::REG_X_LIMIT: axis_limit[0] = cfg_data;
                    mcwp_pkg::REG_Y_LIMIT: axis_limit[1] = cfg_data;
                    mcwp_pkg::REG_Z_LIMIT: axis_limit[2] = cfg_data;
                    mcwp_pkg::REG_X_HOLD:  axis_hold[0]  = cfg_data;
                    mcwp_pkg::REG_Y_HOLD:  axis_hold[1]  = cfg_data;
                    mcwp_pkg::REG_Z_HOLD:  axis_hold[2]  = cfg_data;
                    default: ;
                endcase
            end
            // A result leaving now belongs to a byte taken at an earlier edge,
            // so it is compared before this edge's byte is parsed.
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    $error("result item with none expected: status %0d axis %0d",
                           m_status, m_error_axis);
                    error_count++;
                end else begin
                    want = results_due.pop_front();
                    check_field("status", int'(want.status), int'(m_status));
                    check_field("error_axis", int'(want.axis), int'(m_error_axis));
                    check_field("x_mils", int'(want.x), int'(m_x_mils));
                    check_field("y_mils", int'(want.y), int'(m_y_mils));
                    check_field("z_mils", int'(want.z), int'(m_z_mils));
                end
            end
            if (s_valid && s_ready)
                parse_byte(s_rx_byte);
        end
        pending = results_due.size();
    end

endmodule

@@ tb/sv/motion_command_word_parser_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_command_word_parser_core_tb
// Sends directed and random motion commands byte by byte into the parser,
// with random gaps and result stalls, and rewrites the limit and hold
// registers between phases. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module motion_command_word_parser_core_tb;

    localparam int             CYCLE_LIMIT = 400000;
    localparam int             NUM_PHASES  = 8;
    localparam int             PHASE_BYTES = 130;
    localparam logic [2:0]     REG_SPARE_A = 3'd6;
    localparam logic [2:0]     REG_SPARE_B = 3'd7;
    localparam mcwp_pkg::val_t VAL_ONES    = 17'h1FFFF;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b1;
    logic [2:0]  m_status;
    logic [1:0]  m_error_axis;
    logic [16:0] m_x_mils;
    logic [16:0] m_y_mils;
    logic [16:0] m_z_mils;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = mcwp_pkg::REG_X_LIMIT;
    logic [16:0] cfg_data = '0;

    int   error_count;
    int   pending;
    int   cycle_count = 0;
    int   bytes_sent = 0;
    int   stall_left = 0;
    logic gaps_on = 1'b1;

    motion_command_word_parser_core u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_error_axis (m_error_axis),
        .m_x_mils     (m_x_mils),
        .m_y_mils     (m_y_mils),
        .m_z_mils     (m_z_mils),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    motion_command_word_parser_core_chk u_chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_error_axis (m_error_axis),
        .m_x_mils     (m_x_mils),
        .m_y_mils     (m_y_mils),
        .m_z_mils     (m_z_mils),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .error_count  (error_count),
        .pending      (pending)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side stalls in short random bursts.
    always @(posedge aclk) begin
        if (gaps_on && stall_left == 0 && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 3);
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Called at a rising edge; returns at the edge where the item is taken.
    // Ready is looked at on the falling edge, where it is settled.
    task automatic send_byte(input logic [7:0] b);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(8'(s[i]));
    endtask

    task automatic send_cmd(input string s);
        send_text(s);
        send_byte(mcwp_pkg::ASCII_CR);
    endtask

    task automatic send_digit();
        send_byte(8'(mcwp_pkg::ASCII_0 + $urandom_range(0, 9)));
    endtask

    task automatic send_loose(input int n);
        repeat (n) begin
            if ($urandom_range(0, 3) == 0)
                send_byte(mcwp_pkg::ASCII_DOT);
            else
                send_digit();
        end
    endtask

    // Mostly well-formed numbers; extra digits sometimes run into the
    // seventh character of the field.
    task automatic send_number();
        int kind;
        int used;
        kind = $urandom_range(0, 5);
        used = 7;
        case (kind)
            0: begin send_byte(mcwp_pkg::ASCII_DOT); send_digit(); used = 2; end
            1: begin send_digit(); send_byte(mcwp_pkg::ASCII_DOT); send_digit(); used = 3; end
            2: begin send_digit(); send_digit(); send_byte(mcwp_pkg::ASCII_DOT); used = 3; end
            3: begin send_digit(); used = 6; end
            4: begin send_digit(); send_digit(); used = 6; end
            default: send_loose($urandom_range(1, 7));
        endcase
        send_loose(0);
        repeat ($urandom_range(0, 7 - used)) send_digit();
    endtask

    task automatic send_random_command();
        int          style;
        int          pick;
        logic        lower;
        logic [7:0]  letter;
        style = $urandom_range(0, 19);
        if (style < 2) begin
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 4)) begin
                pick  = $urandom_range(0, 3);
                lower = 1'($urandom_range(0, 1));
                case (pick)
                    0: letter = lower ? mcwp_pkg::ASCII_X_LO : mcwp_pkg::ASCII_X_UP;
                    1: letter = lower ? mcwp_pkg::ASCII_Y_LO : mcwp_pkg::ASCII_Y_UP;
                    2: letter = lower ? mcwp_pkg::ASCII_Z_LO : mcwp_pkg::ASCII_Z_UP;
                    default: letter = lower ? mcwp_pkg::ASCII_F_LO : mcwp_pkg::ASCII_F_UP;
                endcase
                send_byte(letter);
                if ($urandom_range(0, 3) == 0)
                    send_byte(mcwp_pkg::ASCII_SPACE);
                if (pick == 3)
                    send_loose($urandom_range(1, 7));
                else
                    send_number();
            end
            if (style == 2)
                send_byte(mcwp_pkg::ASCII_ETX);
            else if (style == 3)
                send_byte(8'($urandom_range(0, 255)));
            if (style <= 3)
                repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
        end
        send_byte(mcwp_pkg::ASCII_CR);
    endtask

    // Holds the sender until every expected result has come, then lets the
    // block settle for its latency.
    task automatic wait_all_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input mcwp_pkg::val_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        while (!cfg_ready) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic load_axes(input mcwp_pkg::val_t xl, input mcwp_pkg::val_t yl,
                             input mcwp_pkg::val_t zl, input mcwp_pkg::val_t xh,
                             input mcwp_pkg::val_t yh, input mcwp_pkg::val_t zh);
        wait_all_results();
        write_reg(mcwp_pkg::REG_X_LIMIT, xl);
        write_reg(mcwp_pkg::REG_Y_LIMIT, yl);
        write_reg(mcwp_pkg::REG_Z_LIMIT, zl);
        write_reg(mcwp_pkg::REG_X_HOLD, xh);
        write_reg(mcwp_pkg::REG_Y_HOLD, yh);
        write_reg(mcwp_pkg::REG_Z_HOLD, zh);
        // Indexes past the last register must leave everything unchanged.
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                  mcwp_pkg::val_t'($urandom));
        cfg_valid <= 1'b0;
    endtask

    function automatic mcwp_pkg::val_t rand_limit();
        if ($urandom_range(0, 1) == 0)
            return mcwp_pkg::val_t'($urandom_range(50000, 99999));
        return mcwp_pkg::val_t'($urandom_range(0, 99999));
    endfunction

    initial begin
        int start;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed commands under the reset register values.
        send_cmd("X1.5 Y.25 Z12.");
        send_cmd("x12 y3 z99.999");
        send_cmd("F100 X3");
        send_cmd("");
        send_cmd("5.5 X1");
        send_text("X1");
        send_byte(mcwp_pkg::ASCII_ETX);
        send_cmd(" Y2");
        send_byte(mcwp_pkg::ASCII_ETX);
        send_byte(mcwp_pkg::ASCII_CR);
        send_cmd("X1#");
        send_cmd("Y2?Z1");
        send_cmd("Z3-");
        send_cmd("F1a");
        send_cmd("X1234567");
        send_cmd("X..1");
        send_cmd("X12.3456");
        send_cmd("X12 X3");
        send_cmd("Y1.2345 Z.99999");
        send_byte(8'hFF);
        send_cmd("X0");
        send_cmd("x0 y00 z.0");

        // Limits and holds at their edges.
        load_axes(17'd1000, 17'd500, 17'd0, VAL_ONES, 17'd99999, 17'd0);
        send_cmd("X1.001");
        send_cmd("Y.5 Z0");
        send_cmd("X2 Y1 Z.001");
        send_cmd("X.. Y9");
        send_cmd("X1");

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: load_axes('0, '0, '0, 17'd99999, 17'd99999, 17'd99999);
                1: load_axes(17'd99999, 17'd99999, 17'd99999, '0, '0, '0);
                2: load_axes(VAL_ONES, VAL_ONES, VAL_ONES, VAL_ONES, VAL_ONES, VAL_ONES);
                default: load_axes(rand_limit(), rand_limit(), rand_limit(),
                                   mcwp_pkg::val_t'($urandom_range(0, 99999)),
                                   mcwp_pkg::val_t'($urandom_range(0, 99999)),
                                   mcwp_pkg::val_t'($urandom_range(0, 99999)));
            endcase
            gaps_on = (p != 3 && p != NUM_PHASES - 1);
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES)
                send_random_command();
        end

        wait_all_results();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
